### rtl/vop_pkg.sv
// Package for the vignette overlay pixel generator.
// Holds pipeline depths, configuration and mode codes, shared types and the divide-by-255 helper.
// No dependencies.
package vop_pkg;

    localparam int DIV_STAGES    = 17;
    localparam int SQRT_STAGES   = 17;
    localparam int PIPE_LATENCY  = 27;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_BASE_COLOR   = 3'd2,
        CFG_OPACITY      = 3'd3,
        CFG_EFFECT_MODE  = 3'd4,
        CFG_CORNER_RAD   = 3'd5,
        CFG_TOP_ONLY     = 3'd6
    } t_cfg_index;

    localparam logic [3:0] MODE_VIGNETTE = 4'd0;
    localparam logic [3:0] MODE_BLANK    = 4'd1;
    localparam logic [3:0] MODE_FLAT     = 4'd2;
    localparam logic [3:0] MODE_FLAT_ALT = 4'd3;

    typedef enum logic [1:0] {
        CA_KEEP,
        CA_SCALE,
        CA_ZERO
    } t_corner_act;

    typedef struct packed {
        logic vld;
        logic in_frame;
        logic vig;
        logic corner;
    } t_side;

    typedef struct packed {
        t_side       side;
        t_corner_act act;
        logic [7:0]  f;
    } t_tail;

    // Exact floor(v / 255) for v up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

### rtl/vop_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 65536 / den) for num <= den; uses vop_pkg.
module vop_divider import vop_pkg::*; (
    input  logic        i_clk,
    input  logic [24:0] i_num,
    input  logic [24:0] i_den,
    output logic [16:0] o_quo
);

    logic [24:0] r_rem [DIV_STAGES];
    logic [16:0] r_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [25:0] t;
        logic [16:0] quo_in;
        if (k == 0) begin : g_first
            assign t      = {1'b0, i_num};
            assign quo_in = '0;
        end else begin : g_next
            assign t      = {r_rem[k-1], 1'b0};
            assign quo_in = r_quo[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (t >= {1'b0, i_den}) begin
                r_rem[k] <= 25'(t - {1'b0, i_den});
                r_quo[k] <= {quo_in[15:0], 1'b1};
            end else begin
                r_rem[k] <= t[24:0];
                r_quo[k] <= {quo_in[15:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

### rtl/vop_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Computes floor(sqrt(sum * 65536)); uses vop_pkg.
module vop_sqrt import vop_pkg::*; (
    input  logic        i_clk,
    input  logic [16:0] i_sum,
    output logic [16:0] o_root
);

    logic [33:0] r_rad  [SQRT_STAGES];
    logic [19:0] r_rem  [SQRT_STAGES];
    logic [16:0] r_root [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [33:0] rad_in;
        logic [19:0] rem_in;
        logic [16:0] root_in;
        logic [19:0] t;
        logic [19:0] trial;
        if (k == 0) begin : g_first
            assign rad_in  = {1'b0, i_sum, 16'd0};
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        assign t     = {rem_in[17:0], rad_in[33:32]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            r_rad[k] <= {rad_in[31:0], 2'b00};
            if (t >= trial) begin
                r_rem[k]  <= t - trial;
                r_root[k] <= {root_in[15:0], 1'b1};
            end else begin
                r_rem[k]  <= t;
                r_root[k] <= {root_in[15:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

### rtl/vignette_overlay_pixel_generator_unit.sv
// Top level of the vignette overlay pixel generator: configuration registers and pixel pipeline.
// Depends on vop_pkg, vop_divider and vop_sqrt.
//
// Channel   Direction  Handshake                      Payload
// pixel     in         i_start, o_busy (always low)   i_pixel_x, i_pixel_y
// result    out        o_valid strobe, no stall       o_argb_word
// config    in         i_cfg_valid, o_cfg_ready       i_cfg_index, i_cfg_data
//
// One pixel is accepted every cycle; words leave in the order their pixels entered.
// Most of the depth comes from the 17-stage quotient divider and the parallel 17-stage square root.
// Reset is synchronous; it clears all valid bits and returns the configuration registers to their defaults.
// Nothing stalls: the pipeline advances every cycle.
module vignette_overlay_pixel_generator_unit import vop_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    output logic        o_valid,
    output logic [31:0] o_argb_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam logic [12:0] DIM_CAP = 13'(MAX_DIMENSION > 8191 ? 8191 : MAX_DIMENSION);

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [23:0] r_base_color;
    logic [6:0]  r_opacity;
    logic [3:0]  r_effect_mode;
    logic [7:0]  r_corner_radius;
    logic        r_top_only;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 13'd1;
            r_frame_height  <= 13'd1;
            r_base_color    <= '0;
            r_opacity       <= 7'd50;
            r_effect_mode   <= '0;
            r_corner_radius <= '0;
            r_top_only      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width   <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT: r_frame_height  <= i_cfg_data[12:0];
                CFG_BASE_COLOR:   r_base_color    <= i_cfg_data;
                CFG_OPACITY:      r_opacity       <= i_cfg_data[6:0];
                CFG_EFFECT_MODE:  r_effect_mode   <= i_cfg_data[3:0];
                CFG_CORNER_RAD:   r_corner_radius <= i_cfg_data[7:0];
                CFG_TOP_ONLY:     r_top_only      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [12:0] w;
    logic [12:0] h;
    logic [6:0]  op;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [23:0] r_cx2;
    logic [23:0] r_cy2;
    logic [24:0] m2;

    assign w  = (r_frame_width > DIM_CAP) ? DIM_CAP : r_frame_width;
    assign h  = (r_frame_height > DIM_CAP) ? DIM_CAP : r_frame_height;
    assign op = (r_opacity > 7'd100) ? 7'd100 : r_opacity;
    assign cx = w[12:1];
    assign cy = h[12:1];
    assign m2 = 25'(r_cx2) + 25'(r_cy2);

    always_ff @(posedge i_clk) begin
        r_cx2 <= 24'(cx) * 24'(cx);
        r_cy2 <= 24'(cy) * 24'(cy);
    end

    // Stage 1: range check and folding.
    logic [12:0] xe, ye, mx, my, fxe, fye;
    logic        in_frame;
    logic        lower;
    logic        r1_vld, r1_inside, r1_lower;
    logic [11:0] r1_fx, r1_fy;

    assign xe       = {1'b0, i_pixel_x};
    assign ye       = {1'b0, i_pixel_y};
    assign in_frame = (xe < w) && (ye < h);
    assign mx       = w - 13'd1 - xe;
    assign my       = h - 13'd1 - ye;
    assign fxe      = (xe < mx) ? xe : mx;
    assign fye      = (ye < my) ? ye : my;
    assign lower    = {ye, 1'b0} > {1'b0, h - 13'd1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start && !o_busy;
        end
        r1_inside <= in_frame;
        r1_fx     <= fxe[11:0];
        r1_fy     <= fye[11:0];
        r1_lower  <= lower;
    end

    // Stage 2: squares of center and corner offsets.
    logic [11:0] dx, dy;
    logic [7:0]  lx, ly;
    logic        corner;
    logic        r2_vld, r2_inside, r2_corner;
    logic [23:0] r2_dx2, r2_dy2;
    logic [15:0] r2_lx2, r2_ly2;

    assign dx     = cx - r1_fx;
    assign dy     = cy - r1_fy;
    assign corner = (r_corner_radius != 8'd0) && (r1_fx < 12'(r_corner_radius))
                    && (r1_fy < 12'(r_corner_radius)) && !(r_top_only && r1_lower);
    assign lx     = r_corner_radius - 8'd1 - r1_fx[7:0];
    assign ly     = r_corner_radius - 8'd1 - r1_fy[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_inside <= r1_inside;
        r2_corner <= corner;
        r2_dx2    <= 24'(dx) * 24'(dx);
        r2_dy2    <= 24'(dy) * 24'(dy);
        r2_lx2    <= 16'(lx) * 16'(lx);
        r2_ly2    <= 16'(ly) * 16'(ly);
    end

    // Stage 3: distance sums and vignette threshold.
    logic [24:0] d2;
    logic [16:0] s;
    logic        vig;
    t_side       r3_side;
    logic [24:0] r3_d2;
    logic [16:0] r3_s;

    assign d2  = 25'(r2_dx2) + 25'(r2_dy2);
    assign s   = 17'(r2_lx2) + 17'(r2_ly2);
    assign vig = (r_effect_mode == MODE_VIGNETTE) && (m2 != 25'd0)
                 && ({d2, 2'b00} > {2'b00, m2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side <= '0;
        end else begin
            r3_side <= '{vld: r2_vld, in_frame: r2_inside, vig: vig, corner: r2_corner};
        end
        r3_d2 <= d2;
        r3_s  <= s;
    end

    logic [16:0] quo;
    logic [16:0] root;

    vop_divider u_div (
        .i_clk (i_clk),
        .i_num (r3_d2),
        .i_den (m2),
        .o_quo (quo)
    );

    vop_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sum  (r3_s),
        .o_root (root)
    );

    t_side r_side [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_side[k] <= '0;
            end
        end else begin
            r_side[0] <= r3_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stage 4: first squaring of q and corner edge decision.
    logic [33:0]  q_sq;
    logic [15:0]  inner, outer;
    logic [16:0]  diff;
    logic [16:0]  f_prod;
    t_tail        n_tail4;
    t_tail        r_tail4;
    logic [16:0]  r4_q2;

    assign q_sq   = 34'(quo) * 34'(quo);
    assign inner  = {r_corner_radius - 8'd1, 8'd0};
    assign outer  = {r_corner_radius, 8'd0};
    assign diff   = 17'(outer) - root;
    assign f_prod = 17'(diff[8:0]) * 17'd255;

    always_comb begin
        n_tail4.side = r_side[DIV_STAGES-1];
        n_tail4.f    = f_prod[15:8];
        if (!r_side[DIV_STAGES-1].corner || root < 17'(inner)) begin
            n_tail4.act = CA_KEEP;
        end else if (root <= 17'(outer)) begin
            n_tail4.act = CA_SCALE;
        end else begin
            n_tail4.act = CA_ZERO;
        end
    end

    // Stages 5 to 8: fourth power, opacity and scaling to 0..255, then alpha selection by mode.
    logic [33:0]  q2_sq;
    logic [30:0]  p255;
    logic [27:0]  a_prod;
    logic [7:0]   alpha;
    t_tail        r_tail5, r_tail6, r_tail7, r_tail8;
    logic [16:0]  r5_q4;
    logic [23:0]  r6_p;
    logic [14:0]  r7_m;
    logic [7:0]   r8_alpha;

    assign q2_sq  = 34'(r4_q2) * 34'(r4_q2);
    assign p255   = 31'(r6_p) * 31'd255;
    assign a_prod = 28'(r7_m) * 28'd5243;

    always_comb begin
        case (r_effect_mode) inside
            MODE_VIGNETTE:           alpha = r_tail7.side.vig ? a_prod[26:19] : 8'd0;
            MODE_FLAT, MODE_FLAT_ALT: alpha = 8'(op);
            default:                 alpha = 8'd0;
        endcase
    end

    // Stage 9: premultiplied word.
    t_tail        r_tail9;
    logic [31:0]  r9_word;
    logic [31:0]  word;

    assign word = {r8_alpha,
                   div255(16'(r_base_color[7:0]) * 16'(r8_alpha)),
                   div255(16'(r_base_color[15:8]) * 16'(r8_alpha)),
                   div255(16'(r_base_color[23:16]) * 16'(r8_alpha))};

    // Stage 10: corner treatment and output register.
    logic [31:0] scaled;
    logic [31:0] n_out;
    logic        r10_vld;
    logic [31:0] r10_word;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            scaled[b*8 +: 8] = div255(16'(r9_word[b*8 +: 8]) * 16'(r_tail9.f));
        end
        case (r_tail9.act)
            CA_KEEP:  n_out = r9_word;
            CA_SCALE: n_out = scaled;
            default:  n_out = '0;
        endcase
        if (!r_tail9.side.vld || !r_tail9.side.in_frame) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail4  <= '0;
            r_tail5  <= '0;
            r_tail6  <= '0;
            r_tail7  <= '0;
            r_tail8  <= '0;
            r_tail9  <= '0;
            r10_vld  <= 1'b0;
            r10_word <= '0;
        end else begin
            r_tail4  <= n_tail4;
            r_tail5  <= r_tail4;
            r_tail6  <= r_tail5;
            r_tail7  <= r_tail6;
            r_tail8  <= r_tail7;
            r_tail9  <= r_tail8;
            r10_vld  <= r_tail9.side.vld;
            r10_word <= n_out;
        end
        r4_q2    <= q_sq[32:16];
        r5_q4    <= q2_sq[32:16];
        r6_p     <= 24'(r5_q4) * 24'(op);
        r7_m     <= p255[30:16];
        r8_alpha <= alpha;
        r9_word  <= word;
    end

    assign o_valid     = r10_vld;
    assign o_argb_word = r10_word;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LATENCY))
        else $error("result strobe without a matching pixel transaction");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_argb_word == 32'd0)
        else $error("result word not cleared between transactions");

    a_premult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_argb_word[23:16] <= o_argb_word[31:24])
                 && (o_argb_word[15:8] <= o_argb_word[31:24])
                 && (o_argb_word[7:0] <= o_argb_word[31:24]))
        else $error("color channel exceeds alpha in premultiplied word");

endmodule

### test/vop_checker.sv
`timescale 1ns / 100ps
// Checker for the vignette overlay pixel generator: mirrors the configuration writes,
// predicts each overlay word and compares it with the block's output. Depends on vop_pkg.
module vop_checker import vop_pkg::*; #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic        i_valid,
    input  logic [31:0] i_argb_word,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [12:0] width_q, height_q;
    logic [23:0] color_q;
    logic [6:0]  opacity_q;
    logic [3:0]  mode_q;
    logic [7:0]  radius_q;
    logic        top_only_q;
    logic [31:0] word_queue[$];

    assign o_pending = word_queue.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] premultiply(input logic [31:0] a);
        logic [31:0] r, g, b;
        r = color_q[7:0] * a / 255;
        g = color_q[15:8] * a / 255;
        b = color_q[23:16] * a / 255;
        return {a[7:0], r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic logic [31:0] predict_word(input logic [11:0] px, input logic [11:0] py);
        logic [31:0] w, h, x, y, op, fx, fy, v, r, cx, cy, a, f, b;
        logic signed [63:0] dx, dy;
        logic [63:0] d2, m2, q, q2, q4, lx, ly, d, inner, outer;
        w = width_q > MAX_DIMENSION ? MAX_DIMENSION : width_q;
        h = height_q > MAX_DIMENSION ? MAX_DIMENSION : height_q;
        x = px;
        y = py;
        op = opacity_q > 100 ? 100 : opacity_q;
        r = radius_q;
        v = 0;
        if (x >= w || y >= h) return 0;
        fx = (x < w - 1 - x) ? x : w - 1 - x;
        fy = (y < h - 1 - y) ? y : h - 1 - y;
        if (mode_q == MODE_VIGNETTE) begin
            cx = w / 2;
            cy = h / 2;
            dx = $signed({32'd0, fx}) - $signed({32'd0, cx});
            dy = $signed({32'd0, fy}) - $signed({32'd0, cy});
            d2 = dx * dx + dy * dy;
            m2 = cx * cx + cy * cy;
            if (m2 != 0 && 4 * d2 > m2) begin
                q = (d2 << 16) / m2;
                q2 = (q * q) >> 16;
                q4 = (q2 * q2) >> 16;
                a = (q4 * op * 255) / (100 * 65536);
                if (a > 255) a = 255;
                if (a != 0) v = premultiply(a);
            end
        end else if (mode_q == MODE_FLAT || mode_q == MODE_FLAT_ALT) begin
            if (op != 0) v = premultiply(op);
        end
        if (r != 0 && fx < r && fy < r && !(top_only_q && 2 * y > h - 1)) begin
            lx = r - 1 - fx;
            ly = r - 1 - fy;
            d = int_sqrt((lx * lx + ly * ly) << 16);
            inner = 64'(r - 1) << 8;
            outer = 64'(r) << 8;
            if (d >= inner) begin
                if (d <= outer) begin
                    f = ((outer - d) * 255) >> 8;
                    if (f > 255) f = 255;
                    for (int s = 0; s < 32; s += 8) begin
                        b = (v >> s) & 32'hFF;
                        b = (b * f / 255) & 32'hFF;
                        v = (v & ~(32'hFF << s)) | (b << s);
                    end
                end else begin
                    v = 0;
                end
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_q <= 13'd1;
            height_q <= 13'd1;
            color_q <= '0;
            opacity_q <= 7'd50;
            mode_q <= '0;
            radius_q <= '0;
            top_only_q <= 1'b0;
            o_fail_count <= 0;
            word_queue.delete();
        end else begin
            if (i_valid) begin
                if (word_queue.size() == 0) begin
                    $error("argb_word: unexpected result 0x%08h", i_argb_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    logic [31:0] want;
                    want = word_queue.pop_front();
                    if (want !== i_argb_word) begin
                        $error("argb_word: expected 0x%08h, actual 0x%08h", want, i_argb_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) word_queue.push_back(predict_word(i_pixel_x, i_pixel_y));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FRAME_WIDTH:  width_q <= i_cfg_data[12:0];
                    CFG_FRAME_HEIGHT: height_q <= i_cfg_data[12:0];
                    CFG_BASE_COLOR:   color_q <= i_cfg_data;
                    CFG_OPACITY:      opacity_q <= i_cfg_data[6:0];
                    CFG_EFFECT_MODE:  mode_q <= i_cfg_data[3:0];
                    CFG_CORNER_RAD:   radius_q <= i_cfg_data[7:0];
                    CFG_TOP_ONLY:     top_only_q <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for the vignette overlay pixel generator: drives configurations and pixel
// transactions in bursts; checking is done in vop_checker. Depends on vop_pkg and the block.
module tb;
    import vop_pkg::*;

    logic        i_clk, i_rst_n, i_start, i_cfg_valid;
    logic [11:0] i_pixel_x, i_pixel_y;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        o_busy, o_valid, o_cfg_ready;
    logic [31:0] o_argb_word;
    int          fail_count, pending;
    logic [12:0] cur_w, cur_h;

    vignette_overlay_pixel_generator_unit DUT (.*);

    vop_checker checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_pixel_x, .i_pixel_y,
        .i_valid(o_valid), .i_argb_word(o_argb_word), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input t_cfg_index idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) cur_w = data[12:0];
        if (idx == CFG_FRAME_HEIGHT) cur_h = data[12:0];
    endtask

    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
        i_start <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic setup(input logic [12:0] w, input logic [12:0] h, input logic [23:0] col,
                         input logic [6:0] op, input logic [3:0] md, input logic [7:0] rad,
                         input logic top);
        write_reg(CFG_FRAME_WIDTH, 24'(w));
        write_reg(CFG_FRAME_HEIGHT, 24'(h));
        write_reg(CFG_BASE_COLOR, col);
        write_reg(CFG_OPACITY, 24'(op));
        write_reg(CFG_EFFECT_MODE, 24'(md));
        write_reg(CFG_CORNER_RAD, 24'(rad));
        write_reg(CFG_TOP_ONLY, 24'(top));
    endtask

    task automatic random_burst(input int count);
        int sent;
        logic [11:0] x, y;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 3) == 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            repeat ($urandom_range(1, 12)) begin
                if (sent < count) begin
                    if ($urandom_range(0, 9) == 0 || cur_w == 0 || cur_h == 0) begin
                        x = 12'($urandom);
                        y = 12'($urandom);
                    end else begin
                        x = 12'($urandom_range(0, (cur_w > 4096 ? 4096 : cur_w) - 1));
                        y = 12'($urandom_range(0, (cur_h > 4096 ? 4096 : cur_h) - 1));
                    end
                    send_pixel(x, y);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_pixel_x <= '0;
        i_pixel_y <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data <= '0;
        cur_w = 1;
        cur_h = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, one-pixel frame.
        send_pixel(0, 0);
        send_pixel(12'hFFF, 12'hFFF);
        drain();

        setup(64, 48, 24'h80FF40, 100, MODE_VIGNETTE, 10, 0);
        send_pixel(0, 0);
        send_pixel(63, 47);
        send_pixel(32, 24);
        send_pixel(1, 24);
        send_pixel(9, 0);
        send_pixel(64, 0);
        send_pixel(0, 48);
        drain();
        write_reg(CFG_EFFECT_MODE, 24'(MODE_BLANK));
        send_pixel(0, 0);
        send_pixel(5, 5);
        drain();
        setup(13'h1FFF, 13'h1FFF, 24'hFFFFFF, 7'h7F, MODE_FLAT_ALT, 255, 1);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 0);
        send_pixel(0, 4095);
        send_pixel(12'hAAA, 12'h555);
        drain();
        setup(0, 0, 24'h123456, 0, 4'd15, 0, 0);
        send_pixel(0, 0);
        send_pixel(3, 7);
        drain();
        setup(6, 5, 24'hFFFFFF, 100, MODE_FLAT, 8, 0);
        for (int i = 0; i < 6; i++) send_pixel(12'(i), 12'(i % 5));
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            logic [12:0] w, h;
            w = (phase % 4 == 0) ? 13'($urandom_range(1, 16)) : 13'($urandom_range(1, 4200));
            h = (phase % 4 == 0) ? 13'($urandom_range(1, 16)) : 13'($urandom_range(1, 4200));
            setup(w, h, 24'($urandom), 7'($urandom), (phase % 3 == 0) ? MODE_VIGNETTE :
                  4'($urandom), 8'($urandom), 1'($urandom));
            random_burst(105);
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
